// ===== rtl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and fixed widths of the linear cross-correlation core.
// ----------------------------------------------------------------------------
`default_nettype none

package lcc_pkg;

  // Fixed payload widths of the channels
  localparam int IN_W      = 16;
  localparam int LAG_OUT_W = 6;
  localparam int CORR_W    = 42;

  // Width of a series length in a job (holds up to 64 pairs)
  localparam int LEN_W     = 7;

  // One loaded series, handed from the front to the back
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             dropped;
  } job_t;

  // Status of the back part, seen by the front
  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lcc_if.sv =====
// ----------------------------------------------------------------------------
// lcc_in_if / lcc_out_if
// Valid/ready channels carrying sample pairs in and correlation results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcc_in_if
  import lcc_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] f_sample;
  logic signed [IN_W-1:0] g_sample;
  logic                   last_sample;

  modport source (output valid, output f_sample, output g_sample, output last_sample,
                  input ready);
  modport sink   (input valid, input f_sample, input g_sample, input last_sample,
                  output ready);
endinterface

interface lcc_out_if
  import lcc_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [LAG_OUT_W-1:0]     lag_index;
  logic signed [CORR_W-1:0] corr_value;
  logic                     last_result;
  logic                     overflow_flag;

  modport source (output valid, output lag_index, output corr_value, output last_result,
                  output overflow_flag, input ready);
  modport sink   (input valid, input lag_index, input corr_value, input last_result,
                  input overflow_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/linear_cross_correlation_core.sv =====
// ----------------------------------------------------------------------------
// linear_cross_correlation_core
// Loads a series of sample pairs and emits the exact linear cross-correlation
// for every lag, one item per lag.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          handshake
//  samples   in   f_sample, g_sample, last_sample                  valid/ready
//  results   out  lag_index, corr_value, last_result, overflow_flag valid/ready
//
//  Loading accepts pairs back to back while samples are not held off. After
//  the last pair a series of n pairs needs n*(n+1)/2 products, one product
//  per cycle through the single multiply-accumulate pipeline while it is not
//  frozen. The job is handed over through the queue, and the data of each lag
//  passes through the store read, product and output registers.
//  Reset clears the pair count and control only; the sample stores are not cleared.
//  A result waiting at the output freezes the pipeline; samples are held off
//  while a series is queued or being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_cross_correlation_core
  import lcc_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  lcc_in_if.sink    samples,
  lcc_out_if.source results
);

  localparam int AW = $clog2(MAX_LEN);

  back_stat_t             back_stat;
  job_t                   job_in;
  job_t                   job_out;
  logic                   job_push;
  logic                   job_pop;
  logic                   q_full;
  logic                   q_empty;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SAMPLE_BITS-1:0] f_wr;
  logic [SAMPLE_BITS-1:0] g_wr;
  logic                   rd_en;
  logic [AW-1:0]          f_addr;
  logic [AW-1:0]          g_addr;
  logic [SAMPLE_BITS-1:0] f_rd;
  logic [SAMPLE_BITS-1:0] g_rd;

  lcc_front #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .back_stat (back_stat),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .job_push  (job_push),
    .job       (job_in),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .f_wr      (f_wr),
    .g_wr      (g_wr)
  );

  lcc_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .pop     (job_pop),
    .job_out (job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  lcc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_first_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (f_wr),
    .rd_en   (rd_en),
    .rd_addr (f_addr),
    .rd_data (f_rd)
  );

  lcc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_second_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (g_wr),
    .rd_en   (rd_en),
    .rd_addr (g_addr),
    .rd_data (g_rd)
  );

  lcc_back #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_avail (!q_empty),
    .job_pop   (job_pop),
    .stat      (back_stat),
    .rd_en     (rd_en),
    .f_addr    (f_addr),
    .g_addr    (g_addr),
    .f_data    (f_rd),
    .g_data    (g_rd),
    .results   (results)
  );

  // No pair may land in the stores while the engine reads them
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(samples.valid && samples.ready && back_stat.busy))
    else $error("sample item accepted while engine busy");

  // The job queue never takes an entry when full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(job_push && q_full))
    else $error("job queue overflow");

  // The engine starts only on a job taken from the queue
  a_run_after_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(back_stat.busy) |-> $past(job_pop))
    else $error("engine started without a job");

endmodule

`default_nettype wire

// ===== rtl/lcc_ram.sv =====
// ----------------------------------------------------------------------------
// lcc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcc_front.sv =====
// ----------------------------------------------------------------------------
// lcc_front
// Loader: takes sample pairs, writes them to the stores, counts them and
// queues a job when the last pair of a series arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_front
  import lcc_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  lcc_in_if.sink                          samples,
  input  wire back_stat_t                 back_stat,
  input  wire logic                       q_full,
  input  wire logic                       q_empty,
  output logic                            job_push,
  output job_t                            job,
  output logic                            wr_en,
  output logic [$clog2(MAX_LEN)-1:0]      wr_addr,
  output logic [SAMPLE_BITS-1:0]          f_wr,
  output logic [SAMPLE_BITS-1:0]          g_wr
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             accept;
  logic             room;

  // Hold off new pairs while a series is queued or being worked on
  assign samples.ready = !q_full && q_empty && !back_stat.busy;
  assign accept        = samples.valid && samples.ready;
  assign room          = count < CNT_W'(MAX_LEN);

  // Take the low sample bits, or zero-extend into wider stores; narrower samples stay as raw bits, sign
  // is restored at the multiplier
  generate
    if (SAMPLE_BITS <= IN_W) begin : g_trunc
      assign f_wr = samples.f_sample[SAMPLE_BITS-1:0];
      assign g_wr = samples.g_sample[SAMPLE_BITS-1:0];
    end else begin : g_zext
      assign f_wr = {{(SAMPLE_BITS-IN_W){1'b0}}, samples.f_sample};
      assign g_wr = {{(SAMPLE_BITS-IN_W){1'b0}}, samples.g_sample};
    end
  endgenerate

  // Store write while there is room
  assign wr_en   = accept && room;
  assign wr_addr = count[AW-1:0];

  // Hand the series over on the last pair
  assign job_push    = accept && samples.last_sample;
  assign job.len     = LEN_W'(room ? count + CNT_W'(1) : count);
  assign job.dropped = dropped || !room;

  // Count pairs, mark drops, restart after the last pair
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (samples.last_sample) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (room) begin
        count <= count + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcc_job_queue.sv =====
// ----------------------------------------------------------------------------
// lcc_job_queue
// Two-entry queue of series jobs between the loader and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_job_queue
  import lcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t job_in,
  input  wire logic pop,
  output job_t      job_out,
  output logic      full,
  output logic      empty
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = fill == 2'd2;
  assign empty   = fill == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = slot[rd_ptr];

  // Store an entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= job_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcc_back.sv =====
// ----------------------------------------------------------------------------
// lcc_back
// Correlation engine: walks every lag and index, reads both stores, runs one
// multiply-accumulate pipeline and emits one item per lag.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_back
  import lcc_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire job_t                       job,
  input  wire logic                       job_avail,
  output logic                            job_pop,
  output back_stat_t                      stat,
  output logic                            rd_en,
  output logic [$clog2(MAX_LEN)-1:0]      f_addr,
  output logic [$clog2(MAX_LEN)-1:0]      g_addr,
  input  wire logic [SAMPLE_BITS-1:0]     f_data,
  input  wire logic [SAMPLE_BITS-1:0]     g_data,
  lcc_out_if.source                       results
);

  localparam int AW     = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 7;
  localparam int SUM_W  = (ACC_W > CORR_W) ? ACC_W : CORR_W + 1;
  localparam logic signed [SUM_W-1:0] CORR_HI =
    {{(SUM_W-CORR_W+1){1'b0}}, {(CORR_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] CORR_LO = ~CORR_HI;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } back_state_t;

  // Control travelling alongside each product
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last;
    logic                 last_lag;
    logic                 dropped;
    logic [LAG_OUT_W-1:0] lag;
  } tap_t;

  back_state_t state;
  logic [CNT_W-1:0] len;
  logic             dropped;
  logic [AW-1:0]    k;
  logic [AW-1:0]    i;
  logic             issue;
  logic             last_i;
  logic             last_k;
  logic             stall;
  tap_t             tap0;
  tap_t             s1;
  tap_t             s2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sum_c;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [CORR_W-1:0] sat;

  logic                     out_valid;
  logic [LAG_OUT_W-1:0]     out_lag;
  logic signed [CORR_W-1:0] out_corr;
  logic                     out_last;
  logic                     out_ovf;

  // Freeze the pipeline while a finished lag waits for the output slot
  assign stall = s2.valid && s2.last && out_valid && !results.ready;

  assign job_pop   = (state == B_IDLE) && job_avail;
  assign stat.busy = state == B_RUN;

  // Issue one product a cycle while running and not stalled
  assign issue  = (state == B_RUN) && !stall;
  assign rd_en  = issue;
  assign f_addr = i + k;
  assign g_addr = i;
  assign last_i = CNT_W'(i) == len - CNT_W'(k) - CNT_W'(1);
  assign last_k = CNT_W'(k) == len - CNT_W'(1);

  assign tap0.valid    = issue;
  assign tap0.first    = i == '0;
  assign tap0.last     = last_i;
  assign tap0.last_lag = last_k;
  assign tap0.dropped  = dropped;
  assign tap0.lag      = LAG_OUT_W'(k);

  // Sequence lags and indices
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_avail) begin
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (!stall && last_i && last_k) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Load a job, walk i inside each lag, step k at the end of the lag
  always_ff @(posedge clk) begin
    if (job_pop) begin
      len     <= CNT_W'(job.len);
      dropped <= job.dropped;
      k       <= '0;
      i       <= '0;
    end else if (issue) begin
      if (last_i) begin
        i <= '0;
        k <= k + AW'(1);
      end else begin
        i <= i + AW'(1);
      end
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (!stall) begin
      s1 <= tap0;
      s2 <= s1;
    end
  end

  // Multiply the two store samples
  always_ff @(posedge clk) begin
    if (!stall && s1.valid) begin
      prod <= $signed(f_data) * $signed(g_data);
    end
  end

  // Accumulate along the lag
  assign sum_c = (s2.first ? '0 : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (!stall && s2.valid) begin
      acc <= sum_c;
    end
  end

  // Saturate to the result width
  always_comb begin
    sum_w = SUM_W'(sum_c);
    if (sum_w > CORR_HI) begin
      sat = CORR_HI[CORR_W-1:0];
    end else if (sum_w < CORR_LO) begin
      sat = CORR_LO[CORR_W-1:0];
    end else begin
      sat = sum_w[CORR_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall && s2.valid && s2.last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && s2.valid && s2.last) begin
      out_lag  <= s2.lag;
      out_corr <= sat;
      out_last <= s2.last_lag;
      out_ovf  <= s2.dropped;
    end
  end

  assign results.valid         = out_valid;
  assign results.lag_index     = out_lag;
  assign results.corr_value    = out_corr;
  assign results.last_result   = out_last;
  assign results.overflow_flag = out_ovf;

endmodule

`default_nettype wire
